/* hw/rtl/spq_pkg.sv */
// Shared types, codes and sizes for the sorted minimum priority queue.
package spq_pkg;

   localparam int DEFAULT_CAPACITY = 16;
   localparam int VALUE_W          = 32;
   localparam int OCC_W            = 5;

   localparam logic [1:0] OP_INSERT = 2'd0;
   localparam logic [1:0] OP_REMOVE = 2'd1;
   localparam logic [1:0] OP_PEEK   = 2'd2;

   localparam logic [1:0] ST_OK        = 2'd0;
   localparam logic [1:0] ST_OVERFLOW  = 2'd1;
   localparam logic [1:0] ST_UNDERFLOW = 2'd2;

   typedef struct packed {
      logic [1:0]                opcode;
      logic signed [VALUE_W-1:0] value;
   } req_type;

   typedef struct packed {
      logic [1:0]                status;
      logic signed [VALUE_W-1:0] head_value;
      logic [OCC_W-1:0]          occupancy;
   } rsp_type;

   // Broadcast to every cell of the row.
   typedef struct packed {
      logic                      do_insert;
      logic                      do_remove;
      logic signed [VALUE_W-1:0] value;
   } cell_cmd_type;

endpackage

/* hw/rtl/spq_cell.sv */
// One storage cell of the sorted row: holds a value and shifts with its neighbors.
module spq_cell (
   input  logic                               clock,
   input  spq_pkg::cell_cmd_type              cmd,
   input  logic                               occupied,
   input  logic                               le_prev,
   input  logic signed [spq_pkg::VALUE_W-1:0] value_prev,
   input  logic signed [spq_pkg::VALUE_W-1:0] value_next,
   output logic                               le_out,
   output logic signed [spq_pkg::VALUE_W-1:0] value_out
);

   logic signed [spq_pkg::VALUE_W-1:0] value_ff;
   logic signed [spq_pkg::VALUE_W-1:0] value_in;

   // The new value goes behind every stored value that is less than or equal to it.
   assign le_out    = occupied && (value_ff <= cmd.value);
   assign value_out = value_ff;

   always_comb begin
      value_in = value_ff;
      if (cmd.do_insert) begin
         if (!le_out) begin
            value_in = le_prev ? cmd.value : value_prev;
         end
      end else if (cmd.do_remove) begin
         value_in = value_next;
      end
   end

   always_ff @(posedge clock) begin
      value_ff <= value_in;
   end

endmodule

/* hw/rtl/sorted_min_priority_queue_unit.sv */
// Top level of the sorted minimum priority queue: a row of cells and the count.
// The response strobe rsp_valid comes in the cycle after a request is taken.
// Throughput: one request per cycle while busy is low; every cell compares and shifts in that cycle.
// busy is high only during reset; the receiver cannot stall responses.
// Reset empties the queue; cell contents are not cleared and are only read below the count.
module sorted_min_priority_queue_unit #(
   parameter int CAPACITY = spq_pkg::DEFAULT_CAPACITY
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   output logic             busy,
   input  spq_pkg::req_type req_data,
   output logic             rsp_valid,
   output spq_pkg::rsp_type rsp_data
);

   localparam int CNT_W = $clog2(CAPACITY + 1);

   logic [CNT_W-1:0]     count_ff;
   logic [CNT_W-1:0]     count_in;
   logic                 rsp_valid_ff;
   logic                 rsp_valid_in;
   spq_pkg::rsp_type     rsp_data_ff;
   spq_pkg::rsp_type     rsp_data_in;
   spq_pkg::cell_cmd_type cmd;

   logic                 accept;
   logic                 full;
   logic                 empty;

   logic                               le_chain [CAPACITY];
   logic signed [spq_pkg::VALUE_W-1:0] cell_value [CAPACITY];

   assign busy   = reset;
   assign accept = start && !busy;
   assign full   = (count_ff == CNT_W'(CAPACITY));
   assign empty  = (count_ff == '0);

   always_comb begin
      cmd.do_insert = 1'b0;
      cmd.do_remove = 1'b0;
      cmd.value     = req_data.value;
      count_in      = count_ff;
      rsp_data_in.status     = spq_pkg::ST_OK;
      rsp_data_in.head_value = '0;
      unique case (req_data.opcode) inside
         spq_pkg::OP_INSERT: begin
            if (full) begin
               rsp_data_in.status = spq_pkg::ST_OVERFLOW;
            end else begin
               cmd.do_insert = accept;
               count_in      = count_ff + 1'b1;
            end
         end
         spq_pkg::OP_REMOVE, spq_pkg::OP_PEEK: begin
            if (empty) begin
               rsp_data_in.status = spq_pkg::ST_UNDERFLOW;
            end else begin
               rsp_data_in.head_value = cell_value[0];
               if (req_data.opcode == spq_pkg::OP_REMOVE) begin
                  cmd.do_remove = accept;
                  count_in      = count_ff - 1'b1;
               end
            end
         end
         default: begin
         end
      endcase
      rsp_data_in.occupancy = spq_pkg::OCC_W'(count_in);
      rsp_valid_in = accept;
   end

   genvar i;
   generate
      for (i = 0; i < CAPACITY; i++) begin : g_cell
         logic                               le_prev;
         logic signed [spq_pkg::VALUE_W-1:0] value_prev;
         logic signed [spq_pkg::VALUE_W-1:0] value_next;

         // On insert, the head cell takes the new value whenever it is empty or its own value is larger.
         if (i == 0) begin : g_head
            assign le_prev    = 1'b1;
            assign value_prev = '0;
         end else begin : g_body
            assign le_prev    = le_chain[i-1];
            assign value_prev = cell_value[i-1];
         end

         if (i == CAPACITY - 1) begin : g_tail
            assign value_next = '0;
         end else begin : g_inner
            assign value_next = cell_value[i+1];
         end

         spq_cell u_cell (
            .clock      (clock),
            .cmd        (cmd),
            .occupied   (count_ff > CNT_W'(i)),
            .le_prev    (le_prev),
            .value_prev (value_prev),
            .value_next (value_next),
            .le_out     (le_chain[i]),
            .value_out  (cell_value[i])
         );
      end
   endgenerate

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (accept) begin
            count_ff <= count_in;
         end
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

/* hw/rtl/spq_checker.sv */
// Port-level checks for the sorted minimum priority queue, bound to the top level.
module spq_checker #(
   parameter int CAPACITY = spq_pkg::DEFAULT_CAPACITY
) (
   input logic             clock,
   input logic             reset,
   input logic             start,
   input logic             busy,
   input logic             rsp_valid,
   input spq_pkg::rsp_type rsp_data
);

   localparam logic [spq_pkg::OCC_W-1:0] OCC_FULL = spq_pkg::OCC_W'(CAPACITY);

   // Every request taken gives exactly one response in the next cycle.
   a_rsp_follows: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> rsp_valid)
      else $error("request taken without a response");

   a_no_spurious: assert property (@(posedge clock) disable iff (reset)
      !(start && !busy) |=> !rsp_valid)
      else $error("response without a request");

   a_overflow_full: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_data.status == spq_pkg::ST_OVERFLOW) |->
         (rsp_data.occupancy == OCC_FULL && rsp_data.head_value == '0))
      else $error("overflow reported while not full");

   a_underflow_empty: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_data.status == spq_pkg::ST_UNDERFLOW) |->
         (rsp_data.occupancy == '0 && rsp_data.head_value == '0))
      else $error("underflow reported while not empty");

endmodule

bind sorted_min_priority_queue_unit spq_checker #(.CAPACITY(CAPACITY)) u_spq_checker (
   .clock     (clock),
   .reset     (reset),
   .start     (start),
   .busy      (busy),
   .rsp_valid (rsp_valid),
   .rsp_data  (rsp_data)
);
